// ===== rtl/tlb_page_table_translator_macros.svh =====
// Assertion macros used by the checker file of the address translator.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// Check a condition whenever its antecedent holds in the same cycle.
`define TLBPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlbpt check failed in the same cycle");

// Check a condition in the cycle after its antecedent holds.
`define TLBPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlbpt check failed in the following cycle");

`endif

// ===== rtl/tlbpt_pkg.sv =====
// Shared types, constants and codes of the address translator.
`timescale 1ns / 1ps
package tlbpt_pkg;

  // Field widths of the address and the result.
  localparam int ADDR_W     = 16;
  localparam int PAGE_W     = 8;
  localparam int OFFSET_W   = 8;
  localparam int FRAME_W    = 7;
  localparam int PHYS_W     = 15;
  localparam int CNT_W      = 32;
  localparam int OUTCOME_W  = 2;
  localparam int PAGES      = 256;

  // Default table sizes.
  localparam int FRAMES_DEF      = 128;
  localparam int TLB_ENTRIES_DEF = 16;

  // Outcome codes.
  localparam logic [OUTCOME_W-1:0] OUTCOME_TLB_HIT = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_PT_HIT  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FAULT   = 2'd2;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

// ===== rtl/tlbpt_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tlbpt_ctrl.sv =====
// Controller state machine: accepts an address beat, then commits its lookup.
`timescale 1ns / 1ps
module tlbpt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  out_stall,
  input  tlbpt_pkg::dp_status_t status,
  output tlbpt_pkg::dp_cmd_t    cmd
);
  import tlbpt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // Commit once the output register is free or being emptied.
        if (!status.out_full || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tlbpt_dp.sv =====
// Datapath: TLB registers, page map and slot tag memories, counters, output register.
`timescale 1ns / 1ps
module tlbpt_dp #(
  parameter int FRAMES      = tlbpt_pkg::FRAMES_DEF,
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tlbpt_pkg::dp_cmd_t                  cmd,
  output tlbpt_pkg::dp_status_t               status,
  input  logic [tlbpt_pkg::ADDR_W-1:0]        in_logical_address,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [tlbpt_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [tlbpt_pkg::FRAME_W-1:0]       out_frame_number,
  output logic [tlbpt_pkg::PHYS_W-1:0]        out_physical_address,
  output logic [tlbpt_pkg::CNT_W-1:0]         out_fault_total,
  output logic [tlbpt_pkg::CNT_W-1:0]         out_tlb_hit_total,
  output logic [tlbpt_pkg::CNT_W-1:0]         out_access_total
);
  import tlbpt_pkg::*;

  localparam int SLOT_W = $clog2(FRAMES);
  localparam int TIDX_W = $clog2(TLB_ENTRIES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAMES - 1);
  localparam logic [TIDX_W-1:0] TIDX_LAST = TIDX_W'(TLB_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // Latched address of the beat in flight.
  logic [ADDR_W-1:0]   addr_r;
  logic [PAGE_W-1:0]   page;
  logic [OFFSET_W-1:0] offset;

  // TLB held in registers, compared in parallel.
  logic [PAGE_W-1:0]   tlb_tag_r   [TLB_ENTRIES];
  logic [FRAME_W-1:0]  tlb_frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;

  // Reverse map valid bits, one per page.
  logic [PAGES-1:0] map_valid_r;
  logic [PAGES-1:0] map_valid_nxt;

  // Replacement pointers and fill state.
  logic [SLOT_W-1:0] slot_ptr_r;
  logic [TIDX_W-1:0] tlb_ptr_r;
  logic              table_full_r;

  // Running counters.
  logic [CNT_W-1:0] fault_cnt_r;
  logic [CNT_W-1:0] tlb_hit_cnt_r;
  logic [CNT_W-1:0] access_cnt_r;

  // Output register.
  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic [PHYS_W-1:0]    out_phys_r;

  // Memory read data.
  logic [SLOT_W-1:0] map_rd_slot;
  logic [PAGE_W-1:0] slot_rd_tag;

  // Lookup results.
  logic                 tlb_hit;
  logic [FRAME_W-1:0]   tlb_hit_frame;
  logic                 pt_hit;
  logic                 fault;
  logic                 do_fault;
  logic [FRAME_W-1:0]   frame;
  logic [OUTCOME_W-1:0] outcome;

  assign page   = addr_r[ADDR_W-1 -: PAGE_W];
  assign offset = addr_r[OFFSET_W-1:0];

  // Page to slot map: read at the incoming page, written on a fault.
  tlbpt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (PAGES)
  ) u_map_ram (
    .clk   (clk),
    .we    (do_fault),
    .waddr (page),
    .wdata (slot_ptr_r),
    .re    (cmd.accept),
    .raddr (in_logical_address[ADDR_W-1 -: PAGE_W]),
    .rdata (map_rd_slot)
  );

  // Slot to page tags: read at the victim slot to retire its old page.
  tlbpt_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FRAMES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (do_fault),
    .waddr (slot_ptr_r),
    .wdata (page),
    .re    (cmd.accept),
    .raddr (slot_ptr_r),
    .rdata (slot_rd_tag)
  );

  // Parallel TLB compare, lowest matching entry wins.
  always_comb begin
    tlb_hit       = 1'b0;
    tlb_hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!tlb_hit && tlb_valid_r[i] && (tlb_tag_r[i] == page)) begin
        tlb_hit       = 1'b1;
        tlb_hit_frame = tlb_frame_r[i];
      end
    end
  end

  // Outcome and frame selection.
  always_comb begin
    pt_hit   = map_valid_r[page];
    fault    = !tlb_hit && !pt_hit;
    do_fault = cmd.commit && fault;
    if (tlb_hit) begin
      outcome = OUTCOME_TLB_HIT;
      frame   = tlb_hit_frame;
    end else if (pt_hit) begin
      outcome = OUTCOME_PT_HIT;
      frame   = FRAME_W'(map_rd_slot);
    end else begin
      outcome = OUTCOME_FAULT;
      frame   = FRAME_W'(slot_ptr_r);
    end
  end

  // Map valid update: retire the evicted page, then mark the new one.
  always_comb begin
    map_valid_nxt = map_valid_r;
    if (do_fault) begin
      if (table_full_r) begin
        map_valid_nxt[slot_rd_tag] = 1'b0;
      end
      map_valid_nxt[page] = 1'b1;
    end
  end

  // Address latch and TLB entry payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= in_logical_address;
    end
    if (do_fault) begin
      tlb_tag_r[tlb_ptr_r]   <= page;
      tlb_frame_r[tlb_ptr_r] <= FRAME_W'(slot_ptr_r);
    end
  end

  // Control state: valid bits, pointers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_valid_r   <= '0;
      map_valid_r   <= '0;
      slot_ptr_r    <= '0;
      tlb_ptr_r     <= '0;
      table_full_r  <= 1'b0;
      fault_cnt_r   <= '0;
      tlb_hit_cnt_r <= '0;
      access_cnt_r  <= '0;
    end else begin
      map_valid_r <= map_valid_nxt;
      if (cmd.commit) begin
        access_cnt_r <= sat_inc(access_cnt_r);
        if (tlb_hit) begin
          tlb_hit_cnt_r <= sat_inc(tlb_hit_cnt_r);
        end
      end
      if (do_fault) begin
        tlb_valid_r[tlb_ptr_r] <= 1'b1;
        fault_cnt_r            <= sat_inc(fault_cnt_r);
        // Pointers freeze once the fault count has saturated.
        if (fault_cnt_r != CNT_MAX) begin
          if (slot_ptr_r == SLOT_LAST) begin
            slot_ptr_r   <= '0;
            table_full_r <= 1'b1;
          end else begin
            slot_ptr_r <= slot_ptr_r + SLOT_W'(1);
          end
          if (tlb_ptr_r == TIDX_LAST) begin
            tlb_ptr_r <= '0;
          end else begin
            tlb_ptr_r <= tlb_ptr_r + TIDX_W'(1);
          end
        end
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome_r <= outcome;
      out_frame_r   <= frame;
      out_phys_r    <= {frame, offset};
    end
  end

  assign status.out_full      = out_valid_r;
  assign out_valid            = out_valid_r;
  assign out_outcome          = out_outcome_r;
  assign out_frame_number     = out_frame_r;
  assign out_physical_address = out_phys_r;
  // Counters change only at a commit, which loads the output register.
  assign out_fault_total      = fault_cnt_r;
  assign out_tlb_hit_total    = tlb_hit_cnt_r;
  assign out_access_total     = access_cnt_r;

endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// Top level of the address translator with TLB and associative page table.
//
// Input channel: in_valid / in_stall carry one 16-bit logical address per beat
// (page in bits 15..8, offset in bits 7..0). Output channel: out_valid /
// out_stall carry one result beat per address: outcome (TLB hit, page table
// hit or page fault), frame number, physical address and saturating totals.
// A beat moves on a clock edge where valid is high and stall is low.
// An accepted address is latched while the page map and slot tag memories are
// read; its lookup then commits into the output register. One address is in
// flight at a time: the block takes no new address until the lookup of the
// last one has committed, and a fault at commit writes both memories back.
// A finished result waits in the output register while the next address is
// taken; its lookup then commits as soon as the held result leaves.
// When the receiver stalls, the result holds and in_stall rises after the
// next accepted address. Reset (rst_n low, synchronous) empties both tables
// and clears all totals and the replacement pointers; no clearing pass is run.
`timescale 1ns / 1ps
module tlb_page_table_translator #(
  parameter int FRAMES      = tlbpt_pkg::FRAMES_DEF,
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tlbpt_pkg::ADDR_W-1:0]    in_logical_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tlbpt_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [tlbpt_pkg::FRAME_W-1:0]   out_frame_number,
  output logic [tlbpt_pkg::PHYS_W-1:0]    out_physical_address,
  output logic [tlbpt_pkg::CNT_W-1:0]     out_fault_total,
  output logic [tlbpt_pkg::CNT_W-1:0]     out_tlb_hit_total,
  output logic [tlbpt_pkg::CNT_W-1:0]     out_access_total
);
  import tlbpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller.
  tlbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  tlbpt_dp #(
    .FRAMES      (FRAMES),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_logical_address   (in_logical_address),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_outcome          (out_outcome),
    .out_frame_number     (out_frame_number),
    .out_physical_address (out_physical_address),
    .out_fault_total      (out_fault_total),
    .out_tlb_hit_total    (out_tlb_hit_total),
    .out_access_total     (out_access_total)
  );

endmodule

// ===== rtl/tlbpt_checker.sv =====
// Port-level checker of the address translator and its bind statement.
`timescale 1ns / 1ps
`include "tlb_page_table_translator_macros.svh"
module tlbpt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [tlbpt_pkg::OUTCOME_W-1:0] out_outcome,
  input logic [tlbpt_pkg::FRAME_W-1:0]   out_frame_number,
  input logic [tlbpt_pkg::PHYS_W-1:0]    out_physical_address,
  input logic [tlbpt_pkg::CNT_W-1:0]     out_fault_total,
  input logic [tlbpt_pkg::CNT_W-1:0]     out_access_total
);
  import tlbpt_pkg::*;

  // Only one address is in flight: an accepted beat closes the input.
  `TLBPT_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // With an empty output register, an accepted beat commits without waiting and then shows out_valid.
  `TLBPT_ASSERT_NEXT(a_latency, in_valid && !in_stall && !out_valid, ##1 out_valid)

  // A stalled result holds.
  `TLBPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(out_physical_address) && $stable(out_access_total))

  // The physical address carries the frame number in its upper bits.
  `TLBPT_ASSERT_SAME(a_phys_frame, out_valid,
                     out_physical_address[14:8] == out_frame_number)

  // A fault result always counts at least one fault.
  `TLBPT_ASSERT_SAME(a_fault_count, out_valid && (out_outcome == OUTCOME_FAULT),
                     out_fault_total != '0)

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);
